// ----- rtl/lqm_pkg.sv -----
package lqm_pkg;

   // field widths
   localparam int RSSI_W  = 8;
   localparam int MISS_W  = 8;
   localparam int EVENT_W = 2;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // saturation point of the timeout counter
   localparam logic [MISS_W-1:0] MISS_MAX = 8'd255;

   // register reset values
   localparam logic signed [RSSI_W-1:0] ERR_THR_RESET  = -8'sd90;
   localparam logic signed [RSSI_W-1:0] WARN_THR_RESET = -8'sd80;
   localparam logic [MISS_W-1:0]        MISS_LIM_RESET = 8'd3;

   // register indexes (byte address divided by four)
   typedef enum logic [1:0] {
      REG_ERR_THR  = 2'd0,
      REG_WARN_THR = 2'd1,
      REG_MISS_LIM = 2'd2,
      REG_NONE     = 2'd3
   } reg_index_type;

   // event codes on the result channel
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE  = 2'd0,
      EV_WARN  = 2'd1,
      EV_ERROR = 2'd2
   } event_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic signed [RSSI_W-1:0] err_thr;
      logic signed [RSSI_W-1:0] warn_thr;
      logic [MISS_W-1:0]        miss_limit;
   } cfg_type;

endpackage

// ----- rtl/lqm_csr.sv -----
module lqm_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lqm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lqm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [lqm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output lqm_pkg::cfg_type             cfg
);
   import lqm_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_ERR_THR:  cfg_in.err_thr    = csr_pwdata[RSSI_W-1:0];
            REG_WARN_THR: cfg_in.warn_thr   = csr_pwdata[RSSI_W-1:0];
            REG_MISS_LIM: cfg_in.miss_limit = csr_pwdata[MISS_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.err_thr    <= ERR_THR_RESET;
         cfg_ff.warn_thr   <= WARN_THR_RESET;
         cfg_ff.miss_limit <= MISS_LIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux, thresholds sign extended
   always_comb begin
      unique case (reg_sel)
         REG_ERR_THR:  csr_prdata = CSR_DW'(cfg_ff.err_thr);
         REG_WARN_THR: csr_prdata = CSR_DW'(cfg_ff.warn_thr);
         REG_MISS_LIM: csr_prdata = CSR_DW'(cfg_ff.miss_limit);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/lqm_div.sv -----
module lqm_div #(
   parameter int SUM_W = 11,
   parameter int CNT_W = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [SUM_W-1:0]             dividend,
   input  logic [CNT_W-1:0]                    divisor,
   output logic                                done,
   output logic signed [lqm_pkg::RSSI_W-1:0]   quotient
);
   import lqm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;

   logic [CNT_W:0]    rem_shift;
   logic              fits;
   logic [SUM_W-1:0]  quo_signed;

   // one restoring step per cycle, dividend magnitude shifts out as quotient shifts in
   assign rem_shift = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
   assign fits      = rem_shift >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         rem_in  = '0;
         quo_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         div_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         zero_in = (divisor == '0);
      end else if (busy_ff) begin
         rem_in  = fits ? (rem_shift - {1'b0, div_ff}) : rem_shift;
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // restore the sign, empty history averages to zero
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = zero_ff ? '0 : quo_signed[RSSI_W-1:0];
   assign done       = done_ff;

endmodule

// ----- rtl/link_quality_monitor.sv -----
// channel | dir | handshake         | payload
// req     | in  | tvalid/tready     | tuser[0] got_response, tdata[7:0] rssi_sample
// rsp     | out | tvalid/tready     | tdata event, link_up, average_rssi, miss_count
// csr     | in  | psel/penable      | three 8-bit registers at byte addresses 0, 4, 8
//
// a transaction occupies the block while the sequencer steps through read, update,
// divide and finish; its result is set by the bit-serial divider that forms the
// average, one quotient bit a cycle
// one item is in flight at a time; req_tready is high only while the sequencer idles
// a finished result waits in the output register; a stalled rsp side holds the
// sequencer in its final state until the result register is free
// synchronous reset clears the history at once through the fill count
module link_quality_monitor #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] rssi_sample
   input  logic [0:0]                   req_tuser,   // [0] got_response
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,   // [1:0] event_code, [2] link_up,
                                                     // [10:3] average_rssi, [18:11] miss_count
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lqm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lqm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [lqm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import lqm_pkg::*;

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = RSSI_W + $clog2(HISTORY_DEPTH);
   localparam int OUT_W = EVENT_W + 1 + RSSI_W + MISS_W;

   cfg_type cfg;

   state_type                state_ff, state_in;
   logic                     item_resp_ff, item_resp_in;
   logic signed [RSSI_W-1:0] item_rssi_ff, item_rssi_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [CNT_W-1:0]         filled_ff, filled_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [MISS_W-1:0]        miss_ff, miss_in;
   logic                     conn_ff, conn_in;
   logic                     lost_ff, lost_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]         rsp_data_ff, rsp_data_in;
   logic signed [RSSI_W-1:0] rd_data_ff;

   logic signed [RSSI_W-1:0] ring_mem [HISTORY_DEPTH];

   logic                     accept;
   logic                     upd_en;
   logic                     div_start;
   logic                     load_out;
   logic                     div_done;
   logic signed [RSSI_W-1:0] avg;
   logic signed [RSSI_W-1:0] old_sample;
   logic                     ring_full;
   event_type                ev;

   lqm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lqm_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (filled_in),
      .done     (div_done),
      .quotient (avg)
   );

   assign accept = req_tvalid & req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) begin
                       state_in = ST_READ;
                    end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_done) begin
                       state_in = ST_FINISH;
                    end
         ST_FINISH: if (!rsp_valid_ff || rsp_tready) begin
                       state_in = ST_IDLE;
                    end
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      upd_en     = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_READ:   ;
         ST_UPDATE: begin
            upd_en    = 1'b1;
            div_start = 1'b1;
         end
         ST_DIVIDE: ;
         ST_FINISH: load_out = !rsp_valid_ff || rsp_tready;
         default:   ;
      endcase
   end

   // history ring, read address is the slot about to be overwritten
   always_ff @(posedge clock) begin
      if (upd_en && item_resp_ff) begin
         ring_mem[slot_ff] <= item_rssi_ff;
      end
      rd_data_ff <= ring_mem[slot_ff];
   end

   // entries past the fill count hold no valid sample and read as zero
   assign ring_full  = (filled_ff == CNT_W'(HISTORY_DEPTH));
   assign old_sample = ring_full ? rd_data_ff : '0;

   // history and link state update
   always_comb begin
      item_resp_in = item_resp_ff;
      item_rssi_in = item_rssi_ff;
      slot_in      = slot_ff;
      filled_in    = filled_ff;
      sum_in       = sum_ff;
      miss_in      = miss_ff;
      conn_in      = conn_ff;
      lost_in      = lost_ff;
      if (accept) begin
         item_resp_in = req_tuser[0];
         item_rssi_in = req_tdata[RSSI_W-1:0];
      end
      if (upd_en) begin
         lost_in = 1'b0;
         if (item_resp_ff) begin
            miss_in = '0;
            conn_in = 1'b1;
            sum_in  = sum_ff + SUM_W'(item_rssi_ff) - SUM_W'(old_sample);
            slot_in = (slot_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            if (!ring_full) begin
               filled_in = filled_ff + 1'b1;
            end
         end else begin
            if (miss_ff != MISS_MAX) begin
               miss_in = miss_ff + 1'b1;
            end
            if ((miss_in >= cfg.miss_limit) && conn_ff) begin
               conn_in = 1'b0;
               lost_in = 1'b1;
            end
         end
      end
   end

   // threshold compare on the finished average; a missed response gives an error only when the link is lost
   always_comb begin
      if (item_resp_ff) begin
         if (avg < cfg.err_thr) begin
            ev = EV_ERROR;
         end else if (avg < cfg.warn_thr) begin
            ev = EV_WARN;
         end else begin
            ev = EV_NONE;
         end
      end else begin
         ev = lost_ff ? EV_ERROR : EV_NONE;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {miss_ff, avg, conn_ff, ev};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         filled_ff    <= '0;
         sum_ff       <= '0;
         miss_ff      <= '0;
         conn_ff      <= 1'b0;
         lost_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         sum_ff       <= sum_in;
         miss_ff      <= miss_in;
         conn_ff      <= conn_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_resp_ff <= item_resp_in;
      item_rssi_ff <= item_rssi_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24 - OUT_W){1'b0}}, rsp_data_ff};

   // fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("fill count beyond history depth");

   // an empty history carries no sum
   assert property (@(posedge clock) disable iff (reset)
      (filled_ff == '0) |-> (sum_ff == '0))
      else $error("nonzero sum with empty history");

   // the divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // the link is only ever dropped by a timeout
   assert property (@(posedge clock) disable iff (reset)
      (conn_ff && !conn_in) |-> (upd_en && !item_resp_ff))
      else $error("link dropped without a timeout");

   // one item in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("ready right after accepting a transaction");

endmodule
